// ----- rtl/une_pkg.sv -----
// shared types and constants for the upwind node extrapolation block
package une_pkg;

    localparam int unsigned VAL_W   = 32;
    localparam int unsigned DIFF_W  = 33;
    localparam int unsigned SCALE_W = 24;
    localparam int unsigned TINY_W  = 31;
    localparam int unsigned WGT_W   = 17;
    localparam int unsigned QUOT_W  = 16;
    localparam int unsigned MULA_W  = 33;
    localparam int unsigned MULB_W  = 25;
    localparam int unsigned PROD_W  = 58;
    localparam int unsigned SUM_W   = 60;

    localparam logic [WGT_W-1:0] ONE_Q16        = 17'd65536;
    localparam logic [WGT_W-1:0] HALF_Q16       = 17'd32768;
    localparam logic [WGT_W-1:0] THIRD_Q16      = 17'd21845;
    localparam logic [WGT_W-1:0] THIRD_LAST_Q16 = 17'd21846;
    localparam logic [WGT_W-1:0] ZERO_Q16       = 17'd0;

    localparam logic [1:0] MISSING_NONE = 2'd3;

    typedef enum logic [1:0] {
        CFG_SCALE_ZY = 2'd0,
        CFG_SCALE_ZX = 2'd1,
        CFG_SCALE_YX = 2'd2,
        CFG_TINY     = 2'd3
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_CHK,
        ST_WA,
        ST_DA,
        ST_PA,
        ST_WB,
        ST_DB,
        ST_CL,
        ST_BL0,
        ST_BL1,
        ST_BL2,
        ST_BL3
    } t_blend_state;

    typedef struct packed {
        logic       start;
        logic [1:0] count;
        logic       two_way;
        logic [1:0] missing;
    } t_blend_req;

    typedef struct packed {
        logic              valid;
        logic              no_neighbour;
        logic [VAL_W-1:0]  value;
    } t_blend_rsp;

endpackage

// ----- rtl/une_div.sv -----
// iterative restoring divider giving a 16 bit fraction of num over den
module une_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [une_pkg::SUM_W-1:0]     i_num,
    input  logic [une_pkg::SUM_W-1:0]     i_den,
    output logic                          o_done,
    output logic [une_pkg::QUOT_W-1:0]    o_quot
);

    localparam int unsigned CNT_W = $clog2(une_pkg::QUOT_W);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [une_pkg::SUM_W-1:0]     r_rem;
    logic [une_pkg::SUM_W-1:0]     r_den;
    logic [une_pkg::QUOT_W-1:0]    r_quot;
    logic [une_pkg::SUM_W:0]       shifted;
    logic                          fits;

    assign shifted = {r_rem, 1'b0};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(une_pkg::QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= une_pkg::SUM_W'(shifted - {1'b0, r_den});
            end else begin
                r_rem <= shifted[une_pkg::SUM_W-1:0];
            end
            r_quot <= {r_quot[une_pkg::QUOT_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- rtl/une_blend.sv -----
// blend sequencer with the shared multiplier, driving the divider
module une_blend (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  une_pkg::t_blend_req                 i_req,
    input  logic signed [une_pkg::VAL_W-1:0]    i_values [3],
    input  logic signed [une_pkg::DIFF_W-1:0]   i_diffs [3],
    input  logic [une_pkg::SCALE_W-1:0]         i_scale_zy,
    input  logic [une_pkg::SCALE_W-1:0]         i_scale_zx,
    input  logic [une_pkg::SCALE_W-1:0]         i_scale_yx,
    input  logic [une_pkg::TINY_W-1:0]          i_tiny,
    input  logic                                i_take,
    output logic                                o_idle,
    output une_pkg::t_blend_rsp                 o_rsp
);

    une_pkg::t_blend_state r_state;
    une_pkg::t_blend_state n_state;

    logic                                r_two_way;
    logic                                r_none;
    logic                                r_done;
    logic [une_pkg::SCALE_W-1:0]         r_scale0;
    logic signed [une_pkg::PROD_W-1:0]   r_prod;
    logic signed [une_pkg::PROD_W-1:0]   r_a;
    logic signed [une_pkg::PROD_W-1:0]   r_b;
    logic signed [une_pkg::SUM_W-1:0]    r_den;
    logic signed [une_pkg::SUM_W-1:0]    r_acc;
    logic [une_pkg::WGT_W-1:0]           r_f1;
    logic [une_pkg::WGT_W-1:0]           r_f2;
    logic [une_pkg::WGT_W-1:0]           r_f3;

    logic signed [une_pkg::MULA_W-1:0]   mul_a;
    logic signed [une_pkg::MULB_W-1:0]   mul_b;
    logic signed [une_pkg::SUM_W-1:0]    thr;
    logic signed [une_pkg::SUM_W-1:0]    a_ext;
    logic signed [une_pkg::SUM_W-1:0]    b_ext;
    logic signed [une_pkg::SUM_W-1:0]    prod_ext;
    logic signed [une_pkg::SUM_W-1:0]    acc_adj;
    logic [une_pkg::SCALE_W-1:0]         miss_scale;
    logic [une_pkg::WGT_W-1:0]           lim;
    logic [une_pkg::WGT_W-1:0]           f2_clamp;
    logic                                div_start;
    logic [une_pkg::SUM_W-1:0]           div_num;
    logic                                div_done;
    logic [une_pkg::QUOT_W-1:0]          div_quot;

    assign thr      = $signed({13'd0, i_tiny, 16'd0});
    assign a_ext    = une_pkg::SUM_W'(r_a);
    assign b_ext    = une_pkg::SUM_W'(r_b);
    assign prod_ext = une_pkg::SUM_W'(r_prod);
    assign lim      = une_pkg::ONE_Q16 - r_f1;
    assign f2_clamp = (r_f2 > lim) ? lim : r_f2;

    always_comb begin
        case (i_req.missing)
            2'd1:    miss_scale = i_scale_zy;
            2'd2:    miss_scale = i_scale_zx;
            default: miss_scale = i_scale_yx;
        endcase
    end

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            une_pkg::ST_MUL0: begin
                mul_a = i_diffs[0];
                mul_b = $signed({1'b0, r_scale0});
            end
            une_pkg::ST_MUL1: begin
                mul_a = i_diffs[1];
                mul_b = r_two_way ? $signed(une_pkg::MULB_W'(une_pkg::ONE_Q16))
                                  : $signed({1'b0, i_scale_zy});
            end
            une_pkg::ST_MUL2: begin
                mul_a = i_diffs[2];
                mul_b = $signed(une_pkg::MULB_W'(une_pkg::ONE_Q16));
            end
            une_pkg::ST_BL0: begin
                mul_a = une_pkg::MULA_W'(i_values[0]);
                mul_b = $signed(une_pkg::MULB_W'(r_f1));
            end
            une_pkg::ST_BL1: begin
                mul_a = une_pkg::MULA_W'(i_values[1]);
                mul_b = $signed(une_pkg::MULB_W'(r_f2));
            end
            une_pkg::ST_BL2: begin
                mul_a = une_pkg::MULA_W'(i_values[2]);
                mul_b = $signed(une_pkg::MULB_W'(r_f3));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // next state and divider launch
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_num   = une_pkg::SUM_W'(r_a);
        case (r_state)
            une_pkg::ST_IDLE: begin
                if (i_req.start && !r_done) begin
                    if (i_req.count == 2'd0) begin
                        n_state = une_pkg::ST_IDLE;
                    end else if (i_req.count == 2'd1) begin
                        n_state = une_pkg::ST_BL0;
                    end else begin
                        n_state = une_pkg::ST_MUL0;
                    end
                end
            end
            une_pkg::ST_MUL0: n_state = une_pkg::ST_MUL1;
            une_pkg::ST_MUL1: n_state = une_pkg::ST_MUL2;
            une_pkg::ST_MUL2: n_state = une_pkg::ST_SUM;
            une_pkg::ST_SUM:  n_state = une_pkg::ST_CHK;
            une_pkg::ST_CHK: begin
                n_state = (r_den > thr) ? une_pkg::ST_WA : une_pkg::ST_BL0;
            end
            une_pkg::ST_WA: begin
                if (r_a <= 0 || a_ext >= r_den) begin
                    n_state = une_pkg::ST_PA;
                end else begin
                    div_start = 1'b1;
                    n_state   = une_pkg::ST_DA;
                end
            end
            une_pkg::ST_DA: begin
                if (div_done) n_state = une_pkg::ST_PA;
            end
            une_pkg::ST_PA: begin
                n_state = r_two_way ? une_pkg::ST_BL0 : une_pkg::ST_WB;
            end
            une_pkg::ST_WB: begin
                div_num = une_pkg::SUM_W'(r_b);
                if (r_b <= 0 || b_ext >= r_den) begin
                    n_state = une_pkg::ST_CL;
                end else begin
                    div_start = 1'b1;
                    n_state   = une_pkg::ST_DB;
                end
            end
            une_pkg::ST_DB: begin
                if (div_done) n_state = une_pkg::ST_CL;
            end
            une_pkg::ST_CL:  n_state = une_pkg::ST_BL0;
            une_pkg::ST_BL0: n_state = une_pkg::ST_BL1;
            une_pkg::ST_BL1: n_state = une_pkg::ST_BL2;
            une_pkg::ST_BL2: n_state = une_pkg::ST_BL3;
            une_pkg::ST_BL3: n_state = une_pkg::ST_IDLE;
            default:         n_state = une_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= une_pkg::ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_done && i_take) begin
                r_done <= 1'b0;
            end else if (r_state == une_pkg::ST_BL3) begin
                r_done <= 1'b1;
            end else if (r_state == une_pkg::ST_IDLE && i_req.start && !r_done
                         && i_req.count == 2'd0) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            une_pkg::ST_IDLE: begin
                if (i_req.start && !r_done) begin
                    r_two_way <= i_req.two_way;
                    r_none    <= (i_req.count == 2'd0);
                    r_scale0  <= i_req.two_way ? miss_scale : i_scale_zx;
                    r_acc     <= '0;
                    r_f1      <= une_pkg::ONE_Q16;
                    r_f2      <= une_pkg::ZERO_Q16;
                    r_f3      <= une_pkg::ZERO_Q16;
                end
            end
            une_pkg::ST_MUL1: r_a <= r_prod;
            une_pkg::ST_MUL2: begin
                r_b   <= r_prod;
                r_den <= a_ext + prod_ext;
            end
            une_pkg::ST_SUM: r_den <= r_den + prod_ext;
            une_pkg::ST_CHK: begin
                if (r_two_way) begin
                    r_f1 <= une_pkg::HALF_Q16;
                    r_f2 <= une_pkg::HALF_Q16;
                    r_f3 <= une_pkg::ZERO_Q16;
                end else begin
                    r_f1 <= une_pkg::THIRD_Q16;
                    r_f2 <= une_pkg::THIRD_Q16;
                    r_f3 <= une_pkg::THIRD_LAST_Q16;
                end
            end
            une_pkg::ST_WA: begin
                if (r_a <= 0) begin
                    r_f1 <= une_pkg::ZERO_Q16;
                end else if (a_ext >= r_den) begin
                    r_f1 <= une_pkg::ONE_Q16;
                end
            end
            une_pkg::ST_DA: begin
                if (div_done) r_f1 <= {1'b0, div_quot};
            end
            une_pkg::ST_PA: begin
                r_f2 <= lim;
                r_f3 <= une_pkg::ZERO_Q16;
            end
            une_pkg::ST_WB: begin
                if (r_b <= 0) begin
                    r_f2 <= une_pkg::ZERO_Q16;
                end else if (b_ext >= r_den) begin
                    r_f2 <= une_pkg::ONE_Q16;
                end
            end
            une_pkg::ST_DB: begin
                if (div_done) r_f2 <= {1'b0, div_quot};
            end
            une_pkg::ST_CL: begin
                r_f2 <= f2_clamp;
                r_f3 <= lim - f2_clamp;
            end
            une_pkg::ST_BL1: r_acc <= prod_ext;
            une_pkg::ST_BL2: r_acc <= r_acc + prod_ext;
            une_pkg::ST_BL3: r_acc <= r_acc + prod_ext;
            default: begin
            end
        endcase
    end

    une_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // round toward zero on the final shift
    assign acc_adj = r_acc + (r_acc[une_pkg::SUM_W-1] ? une_pkg::SUM_W'(65535)
                                                      : une_pkg::SUM_W'(0));

    assign o_idle             = (r_state == une_pkg::ST_IDLE) && !r_done;
    assign o_rsp.valid        = r_done;
    assign o_rsp.no_neighbour = r_none;
    assign o_rsp.value        = acc_adj[47:16];

endmodule

// ----- rtl/upwind_node_extrapolation.sv -----
// top level: axis capture, configuration registers and result register
// Upwind node update for fast-marching extrapolation, Q16.16 fixed point.
// Input stream: one request per grid axis of a node. s_axis_tdata carries
// the centre and neighbour level-set and field values, s_axis_tuser the
// two neighbour usable flags, s_axis_tlast marks the node's final axis.
// A node also ends on the axis whose position equals DIMENSIONS.
// Output stream: one request per node, m_axis_tdata the extrapolated value,
// m_axis_tuser set when no axis had a usable neighbour.
// A non-final axis is only captured. The final axis occupies the blend
// sequencer, whose run with one or more neighbours is set by the
// single shared multiplier (one product per cycle) and the radix-2
// divider (one quotient bit per step, up to two weights per node).
// s_axis_tready is low while the sequencer works on a node.
// The result sits in an output register; the next node's axes are taken
// while it waits, and the sequencer holds a finished blend until that
// register frees up, so a stalled receiver stops input only then.
// Configuration: i_cfg_we writes register i_cfg_index (0 scale z/y, 1 scale z/x,
// 2 scale y/x, 3 small-denominator threshold); write only while idle (not enforced).
// Reset is synchronous, active low; scales return to 1.0, threshold to 1.
module upwind_node_extrapolation #(
    parameter int DIMENSIONS = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // centre_level, low_level, high_level, low_field, high_field
    input  logic [159:0]  s_axis_tdata,
    // low_usable, high_usable
    input  logic [1:0]    s_axis_tuser,
    input  logic          s_axis_tlast,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // node_value
    output logic [31:0]   m_axis_tdata,
    // no_neighbour
    output logic          m_axis_tuser,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [30:0]   i_cfg_data
);

    localparam logic [1:0] LP_DIMS = 2'(DIMENSIONS);

    logic [une_pkg::SCALE_W-1:0]          r_scale_zy;
    logic [une_pkg::SCALE_W-1:0]          r_scale_zx;
    logic [une_pkg::SCALE_W-1:0]          r_scale_yx;
    logic [une_pkg::TINY_W-1:0]           r_tiny;

    logic signed [une_pkg::VAL_W-1:0]     r_values [3];
    logic signed [une_pkg::DIFF_W-1:0]    r_diffs [3];
    logic [1:0]                           r_count;
    logic [1:0]                           r_axis_pos;
    logic [1:0]                           r_missing;
    logic                                 r_start;
    logic                                 r_out_valid;
    logic [une_pkg::VAL_W-1:0]            r_out_value;
    logic                                 r_out_none;

    logic signed [une_pkg::VAL_W-1:0]     centre;
    logic signed [une_pkg::VAL_W-1:0]     lo_lvl;
    logic signed [une_pkg::VAL_W-1:0]     hi_lvl;
    logic signed [une_pkg::VAL_W-1:0]     lo_fld;
    logic signed [une_pkg::VAL_W-1:0]     hi_fld;
    logic                                 lo_ok;
    logic                                 hi_ok;
    logic                                 take_low;
    logic                                 node_end;
    logic                                 accept;
    logic                                 take;
    logic                                 seq_idle;
    une_pkg::t_blend_req                  req;
    une_pkg::t_blend_rsp                  rsp;

    assign centre   = s_axis_tdata[31:0];
    assign lo_lvl   = s_axis_tdata[63:32];
    assign hi_lvl   = s_axis_tdata[95:64];
    assign lo_fld   = s_axis_tdata[127:96];
    assign hi_fld   = s_axis_tdata[159:128];
    assign lo_ok    = s_axis_tuser[0];
    assign hi_ok    = s_axis_tuser[1];
    assign take_low = lo_ok && (!hi_ok || lo_lvl <= hi_lvl);
    assign node_end = s_axis_tlast || (r_axis_pos >= LP_DIMS);

    assign s_axis_tready = seq_idle && !r_start;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign take          = rsp.valid && (!r_out_valid || m_axis_tready);

    assign req.start   = r_start;
    assign req.count   = r_count;
    assign req.two_way = (LP_DIMS == 2'd2) || (r_count == 2'd2);
    assign req.missing = r_missing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_zy <= une_pkg::SCALE_W'(une_pkg::ONE_Q16);
            r_scale_zx <= une_pkg::SCALE_W'(une_pkg::ONE_Q16);
            r_scale_yx <= une_pkg::SCALE_W'(une_pkg::ONE_Q16);
            r_tiny     <= une_pkg::TINY_W'(1);
        end else if (i_cfg_we) begin
            case (une_pkg::t_cfg_index'(i_cfg_index))
                une_pkg::CFG_SCALE_ZY: r_scale_zy <= i_cfg_data[une_pkg::SCALE_W-1:0];
                une_pkg::CFG_SCALE_ZX: r_scale_zx <= i_cfg_data[une_pkg::SCALE_W-1:0];
                une_pkg::CFG_SCALE_YX: r_scale_yx <= i_cfg_data[une_pkg::SCALE_W-1:0];
                une_pkg::CFG_TINY:     r_tiny     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // per-node axis collection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || take) begin
            for (int i = 0; i < 3; i++) begin
                r_values[i] <= '0;
                r_diffs[i]  <= '0;
            end
            r_count    <= 2'd0;
            r_axis_pos <= 2'd1;
            r_missing  <= une_pkg::MISSING_NONE;
            r_start    <= 1'b0;
        end else begin
            if (!seq_idle) begin
                r_start <= 1'b0;
            end
            if (accept) begin
                if (lo_ok || hi_ok) begin
                    if (r_count != 2'd3) begin
                        r_values[r_count] <= take_low ? lo_fld : hi_fld;
                        r_diffs[r_count]  <= une_pkg::DIFF_W'(centre)
                                           - une_pkg::DIFF_W'(take_low ? lo_lvl : hi_lvl);
                        r_count           <= r_count + 2'd1;
                    end
                end else begin
                    r_missing <= r_axis_pos;
                end
                if (node_end) begin
                    r_start <= 1'b1;
                end else begin
                    r_axis_pos <= r_axis_pos + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_value <= rsp.value;
            r_out_none  <= rsp.no_neighbour;
        end
    end

    une_blend u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .i_values   (r_values),
        .i_diffs    (r_diffs),
        .i_scale_zy (r_scale_zy),
        .i_scale_zx (r_scale_zx),
        .i_scale_yx (r_scale_yx),
        .i_tiny     (r_tiny),
        .i_take     (take),
        .o_idle     (seq_idle),
        .o_rsp      (rsp)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_none;

endmodule
